// File: hdl/qhe_pkg.sv
// ----------------------------------------------------------------------------
// qhe_pkg
// Shared widths, latencies, types and coefficient weights for the quintic
// Hermite curve evaluator.
// ----------------------------------------------------------------------------
package qhe_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int U_W       = 18;
   localparam int UC_W      = FRAC_BITS + 1;
   localparam int ACC_W     = 48;
   localparam int NTERM     = 6;
   localparam int NLANE     = 3;
   localparam int NREG      = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [UC_W-1:0] U_ONE = UC_W'(1 << FRAC_BITS);

   // Stationary point threshold: S * 10^6 < 2^(2*FRAC_BITS).
   localparam logic [63:0] STAT_LIMIT = ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd1000000;

   localparam int HORNER_LAT = 2 * (NTERM - 1) + 1;
   localparam int CURV_LAT   = 69;
   localparam int PIPE_LAT   = 1 + HORNER_LAT + CURV_LAT;

   localparam int LANE_POS   = 0;
   localparam int LANE_SLOPE = 1;
   localparam int LANE_BEND  = 2;

   typedef logic signed [ACC_W-1:0] acc_type;
   typedef acc_type [NTERM-1:0]     poly_type;
   typedef poly_type [NLANE-1:0]    lane_type;

   // Weights of the six endpoint values in each doubled polynomial coefficient.
   // Order of the values: start pos, start vel, start acc, end pos, end vel, end acc.
   localparam int WEIGHT [NLANE][NTERM][NREG] = '{
      '{ '{   2,   0,   0,    0,   0,   0 },
         '{   0,   2,   0,    0,   0,   0 },
         '{   0,   0,   1,    0,   0,   0 },
         '{ -20, -12,  -3,   20,  -8,   1 },
         '{  30,  16,   3,  -30,  14,  -2 },
         '{ -12,  -6,  -1,   12,  -6,   1 } },
      '{ '{   0,   2,   0,    0,   0,   0 },
         '{   0,   0,   2,    0,   0,   0 },
         '{ -60, -36,  -9,   60, -24,   3 },
         '{ 120,  64,  12, -120,  56,  -8 },
         '{ -60, -30,  -5,   60, -30,   5 },
         '{   0,   0,   0,    0,   0,   0 } },
      '{ '{   0,   0,   2,    0,   0,   0 },
         '{-120, -72, -18,  120, -48,   6 },
         '{ 360, 192,  36, -360, 168, -24 },
         '{-240,-120, -20,  240,-120,  20 },
         '{   0,   0,   0,    0,   0,   0 },
         '{   0,   0,   0,    0,   0,   0 } }
   };

endpackage

// File: hdl/qhe_coef.sv
// ----------------------------------------------------------------------------
// qhe_coef
// Endpoint registers and the doubled polynomial coefficients derived from them.
// ----------------------------------------------------------------------------
module qhe_coef import qhe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data,
   output lane_type             poly_x_ff,
   output lane_type             poly_y_ff
);

   logic [63:0] regs_ff [NREG];
   logic [NREG*WORD_BITS-1:0] vals_x;
   logic [NREG*WORD_BITS-1:0] vals_y;

   function automatic acc_type weigh(input int l, input int k,
                                     input logic [NREG*WORD_BITS-1:0] vals);
      acc_type sum;
      acc_type term;
      sum = '0;
      for (int i = 0; i < NREG; i++) begin
         term = ACC_W'($signed(vals[i*WORD_BITS +: WORD_BITS]));
         sum  = sum + ACC_W'(WEIGHT[l][k][i]) * term;
      end
      return sum;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREG; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (csr_valid && (csr_index < CSR_IDX_W'(NREG))) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   always_comb begin
      for (int i = 0; i < NREG; i++) begin
         vals_x[i*WORD_BITS +: WORD_BITS] = regs_ff[i][2*WORD_BITS-1:WORD_BITS];
         vals_y[i*WORD_BITS +: WORD_BITS] = regs_ff[i][WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < NLANE; l++) begin
         for (int k = 0; k < NTERM; k++) begin
            poly_x_ff[l][k] <= weigh(l, k, vals_x);
            poly_y_ff[l][k] <= weigh(l, k, vals_y);
         end
      end
   end

endmodule

// File: hdl/qhe_horner.sv
// ----------------------------------------------------------------------------
// qhe_horner
// One pipelined Horner lane: multiply and round-accumulate stages per term,
// then the final halving and saturation.
// ----------------------------------------------------------------------------
module qhe_horner import qhe_pkg::*; (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [UC_W-1:0]             u_in,
   input  poly_type                    coef,
   output logic signed [WORD_BITS-1:0] result_ff
);

   localparam int STEPS  = NTERM - 1;
   localparam int PROD_W = ACC_W + UC_W + 1;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam acc_type SAT_HI = {{(ACC_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
   localparam acc_type SAT_LO = {{(ACC_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff [STEPS];
   acc_type                  acc_ff  [STEPS];
   logic [UC_W-1:0]          u_ff    [2*STEPS-2];
   acc_type                  hsum;
   acc_type                  halfv;

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff[0] <= u_in;
         for (int j = 1; j < 2*STEPS-2; j++) begin
            u_ff[j] <= u_ff[j-1];
         end
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      acc_type                  acc_prev;
      logic [UC_W-1:0]          u_k;
      logic signed [PROD_W-1:0] rsum;
      logic signed [PROD_W-1:0] rnd;

      if (k == 0) begin : g_first
         assign acc_prev = coef[NTERM-1];
         assign u_k      = u_in;
      end else begin : g_next
         assign acc_prev = acc_ff[k-1];
         assign u_k      = u_ff[2*k-1];
      end

      // Round half away from zero: add half, less one for negative values.
      assign rsum = prod_ff[k] + $signed(HALF)
                    - $signed(PROD_W'(prod_ff[k][PROD_W-1]));
      assign rnd  = rsum >>> FRAC_BITS;

      always_ff @(posedge clock) begin
         if (adv) begin
            prod_ff[k] <= acc_prev * $signed({1'b0, u_k});
            acc_ff[k]  <= rnd[ACC_W-1:0] + coef[NTERM-2-k];
         end
      end
   end

   assign hsum  = acc_ff[STEPS-1]
                  + $signed({{(ACC_W-1){1'b0}}, ~acc_ff[STEPS-1][ACC_W-1]});
   assign halfv = hsum >>> 1;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (halfv > SAT_HI) begin
            result_ff <= SAT_HI[WORD_BITS-1:0];
         end else if (halfv < SAT_LO) begin
            result_ff <= SAT_LO[WORD_BITS-1:0];
         end else begin
            result_ff <= halfv[WORD_BITS-1:0];
         end
      end
   end

endmodule

// File: hdl/qhe_curv.sv
// ----------------------------------------------------------------------------
// qhe_curv
// Curvature magnitude: products, pipelined integer square root, split
// denominator multiply and a pipelined restoring divider.
// ----------------------------------------------------------------------------
module qhe_curv import qhe_pkg::*; (
   input  logic                        clock,
   input  logic                        adv,
   input  logic signed [WORD_BITS-1:0] slope_x,
   input  logic signed [WORD_BITS-1:0] slope_y,
   input  logic signed [WORD_BITS-1:0] bend_x,
   input  logic signed [WORD_BITS-1:0] bend_y,
   output logic [WORD_BITS-1:0]        curv_ff
);

   localparam int SQ_STEPS  = 32;
   localparam int DIV_STEPS = WORD_BITS;

   // Products.
   logic signed [63:0] p1_ff, p2_ff, sxx_ff, syy_ff;
   // Magnitude of the cross product and squared speed.
   logic signed [64:0] diff;
   logic [63:0]        mag_ff, s_ff;
   logic               stat_ff;
   // Square root pipeline.
   logic [63:0]        sq_x_ff   [SQ_STEPS];
   logic [63:0]        sq_r_ff   [SQ_STEPS];
   logic [63:0]        sq_s_ff   [SQ_STEPS];
   logic [63:0]        sq_mag_ff [SQ_STEPS];
   logic               sq_stat_ff[SQ_STEPS];
   // Denominator.
   logic [63:0]        pp_lo_ff, pp_hi_ff, pp_mag_ff;
   logic               pp_stat_ff;
   logic [95:0]        den_ff;
   logic [63:0]        den_mag_ff;
   logic               den_stat_ff;
   // Divider pipeline.
   logic [127:0]       dv_rem_ff [DIV_STEPS];
   logic [95:0]        dv_den_ff [DIV_STEPS];
   logic [WORD_BITS-1:0] dv_q_ff [DIV_STEPS];
   logic               dv_stat_ff[DIV_STEPS];
   logic               dv_sat_ff [DIV_STEPS];

   assign diff = 65'(p1_ff) - 65'(p2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff   <= slope_x * bend_y;
         p2_ff   <= slope_y * bend_x;
         sxx_ff  <= slope_x * slope_x;
         syy_ff  <= slope_y * slope_y;
         mag_ff  <= diff[64] ? 64'(-diff) : diff[63:0];
         s_ff    <= sxx_ff + syy_ff;
         stat_ff <= ((sxx_ff + syy_ff) <= STAT_LIMIT);
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam logic [63:0] BITV = 64'd1 << (62 - 2*k);
      logic [63:0] x_in, r_in, s_in, mag_in, trial;
      logic        stat_in;

      if (k == 0) begin : g_first
         assign x_in    = s_ff;
         assign r_in    = '0;
         assign s_in    = s_ff;
         assign mag_in  = mag_ff;
         assign stat_in = stat_ff;
      end else begin : g_next
         assign x_in    = sq_x_ff[k-1];
         assign r_in    = sq_r_ff[k-1];
         assign s_in    = sq_s_ff[k-1];
         assign mag_in  = sq_mag_ff[k-1];
         assign stat_in = sq_stat_ff[k-1];
      end

      assign trial = r_in + BITV;

      always_ff @(posedge clock) begin
         if (adv) begin
            if (x_in >= trial) begin
               sq_x_ff[k] <= x_in - trial;
               sq_r_ff[k] <= (r_in >> 1) + BITV;
            end else begin
               sq_x_ff[k] <= x_in;
               sq_r_ff[k] <= r_in >> 1;
            end
            sq_s_ff[k]    <= s_in;
            sq_mag_ff[k]  <= mag_in;
            sq_stat_ff[k] <= stat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_lo_ff    <= 64'(sq_s_ff[SQ_STEPS-1][31:0]) * 64'(sq_r_ff[SQ_STEPS-1][31:0]);
         pp_hi_ff    <= 64'(sq_s_ff[SQ_STEPS-1][63:32]) * 64'(sq_r_ff[SQ_STEPS-1][31:0]);
         pp_mag_ff   <= sq_mag_ff[SQ_STEPS-1];
         pp_stat_ff  <= sq_stat_ff[SQ_STEPS-1];
         den_ff      <= {32'd0, pp_lo_ff} + {pp_hi_ff, 32'd0};
         den_mag_ff  <= pp_mag_ff;
         den_stat_ff <= pp_stat_ff;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int SH = DIV_STEPS - 1 - j;
      logic [127:0]         rem_in, t;
      logic [95:0]          den_in;
      logic [WORD_BITS-1:0] q_in;
      logic                 stat_in, sat_in;

      if (j == 0) begin : g_first
         assign rem_in  = {32'd0, den_mag_ff, 32'd0};
         assign den_in  = den_ff;
         assign q_in    = '0;
         assign stat_in = den_stat_ff;
         // Quotient would not fit: numerator reaches the denominator shifted by a word.
         assign sat_in  = ({32'd0, den_mag_ff, 32'd0} >= {den_ff, 32'd0});
      end else begin : g_next
         assign rem_in  = dv_rem_ff[j-1];
         assign den_in  = dv_den_ff[j-1];
         assign q_in    = dv_q_ff[j-1];
         assign stat_in = dv_stat_ff[j-1];
         assign sat_in  = dv_sat_ff[j-1];
      end

      assign t = {32'd0, den_in} << SH;

      always_ff @(posedge clock) begin
         if (adv) begin
            if (rem_in >= t) begin
               dv_rem_ff[j] <= rem_in - t;
               dv_q_ff[j]   <= q_in | (WORD_BITS'(1) << SH);
            end else begin
               dv_rem_ff[j] <= rem_in;
               dv_q_ff[j]   <= q_in;
            end
            dv_den_ff[j]  <= den_in;
            dv_stat_ff[j] <= stat_in;
            dv_sat_ff[j]  <= sat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (dv_stat_ff[DIV_STEPS-1]) begin
            curv_ff <= '0;
         end else if (dv_sat_ff[DIV_STEPS-1]) begin
            curv_ff <= '1;
         end else begin
            curv_ff <= dv_q_ff[DIV_STEPS-1];
         end
      end
   end

endmodule

// File: hdl/quintic_hermite_evaluator.sv
// ----------------------------------------------------------------------------
// quintic_hermite_evaluator
// Pipeline: 81 register stages from an accepted request to its result
// (1 clamp stage, 11 Horner stages, 69 curvature stages set by the
// square root and divider).
// Throughput: one request per cycle; the whole pipeline halts on a stall.
// Reset clears the endpoint registers and all valid bits; data regs are not reset.
// ----------------------------------------------------------------------------
module quintic_hermite_evaluator import qhe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // Request channel.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // [17:0] u_param, [23:18] zero
   // Result channel.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [31:0] pos_x, [63:32] pos_y, [95:64] slope_x, [127:96] slope_y,
   // [159:128] bend_x, [191:160] bend_y, [223:192] curvature
   output logic [223:0]         rsp_tdata,
   // Configuration write channel.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   // Horner outputs that travel beside the curvature pipeline.
   typedef struct packed {
      logic signed [WORD_BITS-1:0] bend_y;
      logic signed [WORD_BITS-1:0] bend_x;
      logic signed [WORD_BITS-1:0] slope_y;
      logic signed [WORD_BITS-1:0] slope_x;
      logic signed [WORD_BITS-1:0] pos_y;
      logic signed [WORD_BITS-1:0] pos_x;
   } motion_type;

   logic                        adv;
   logic [PIPE_LAT-1:0]         vld_ff;
   logic signed [U_W-1:0]       u_raw;
   logic [UC_W-1:0]             u_in;
   logic [UC_W-1:0]             u_ff;
   lane_type                    poly_x, poly_y;
   logic signed [WORD_BITS-1:0] res_x [NLANE];
   logic signed [WORD_BITS-1:0] res_y [NLANE];
   motion_type                  motion;
   motion_type                  dly_ff [CURV_LAT];
   logic [WORD_BITS-1:0]        curv;

   // Every stage moves together whenever the output register is free or
   // its result is being taken this cycle.
   assign adv        = !vld_ff[PIPE_LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[PIPE_LAT-1];

   // Configuration writes are always accepted.
   assign csr_ready = 1'b1;

   qhe_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .poly_x_ff (poly_x),
      .poly_y_ff (poly_y)
   );

   // Clamp the curve parameter to the closed unit interval.
   assign u_raw = $signed(req_tdata[U_W-1:0]);
   always_comb begin
      if (u_raw < 0) begin
         u_in = '0;
      end else if (u_raw > $signed({1'b0, U_ONE})) begin
         u_in = U_ONE;
      end else begin
         u_in = u_raw[UC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff <= u_in;
      end
   end

   // Six Horner lanes: position, slope and bend for each axis.
   for (genvar l = 0; l < NLANE; l++) begin : g_lane
      qhe_horner u_hx (
         .clock     (clock),
         .adv       (adv),
         .u_in      (u_ff),
         .coef      (poly_x[l]),
         .result_ff (res_x[l])
      );
      qhe_horner u_hy (
         .clock     (clock),
         .adv       (adv),
         .u_in      (u_ff),
         .coef      (poly_y[l]),
         .result_ff (res_y[l])
      );
   end

   assign motion.pos_x   = res_x[LANE_POS];
   assign motion.pos_y   = res_y[LANE_POS];
   assign motion.slope_x = res_x[LANE_SLOPE];
   assign motion.slope_y = res_y[LANE_SLOPE];
   assign motion.bend_x  = res_x[LANE_BEND];
   assign motion.bend_y  = res_y[LANE_BEND];

   // The curvature uses the saturated slope and bend values.
   qhe_curv u_curv (
      .clock   (clock),
      .adv     (adv),
      .slope_x (motion.slope_x),
      .slope_y (motion.slope_y),
      .bend_x  (motion.bend_x),
      .bend_y  (motion.bend_y),
      .curv_ff (curv)
   );

   // Delay line keeps the Horner results aligned with the curvature.
   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ff[0] <= motion;
         for (int i = 1; i < CURV_LAT; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign rsp_tdata = {curv, dly_ff[CURV_LAT-1]};

   // An accepted request always occupies the first stage on the next cycle.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted request missing from first stage");

   // The clamped parameter never exceeds one.
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> (u_ff <= U_ONE))
      else $error("clamped parameter out of range");

   // Reset empties the pipeline.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled pipeline keeps its occupancy.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline occupancy changed during a stall");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quintic Hermite curve evaluator. The endpoint
// registers are loaded through the CSR channel while the block is idle. A
// bursty driver streams curve parameters, and a monitor predicts position,
// derivatives and curvature for every accepted request. The result port
// stalls on its own pattern, and once it holds off long enough to back the
// pipeline up into the request port.
// ----------------------------------------------------------------------------
module tb;
   import qhe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int IDLE_LIMIT      = 4000;
   localparam int SETTLE_CYCLES   = PIPE_LAT + 20;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [223:0]         rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_data;

   quintic_hermite_evaluator DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Local copy of the six endpoint registers, updated on every CSR write below NREG.
   logic [63:0]  endpoint_regs [NREG];
   // Parameters waiting to be sent, and curve samples waiting to come back.
   logic [17:0]  pending_params [$];
   logic [223:0] expected_samples [$];

   int  error_count    = 0;
   int  accepted_count = 0;
   bit  param_taken    = 0;
   bit  any_activity   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Curve sample predictor.
   // ------------------------------------------------------------------------

   // Drops s fraction bits, rounding half away from zero.
   function automatic longint round_frac(longint v, int s);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) << (s - 1))) >>> s;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic longint clip_word(longint v);
      if (v < -longint'(64'sd2147483648)) return -longint'(64'sd2147483648);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      return v;
   endfunction

   // Horner evaluation over doubled coefficients, then the final halving.
   function automatic longint horner_eval(longint c[NTERM], int n, longint u);
      longint acc;
      acc = c[n-1];
      for (int k = n - 2; k >= 0; k--)
         acc = round_frac(acc * u, FRAC_BITS) + c[k];
      return clip_word(round_frac(acc, 1));
   endfunction

   // Position, slope and bend of one axis; high_half selects x.
   function automatic void eval_axis(bit high_half, longint u,
                                     output longint pos, output longint slope,
                                     output longint bend);
      longint v [NREG];
      longint c [NTERM];
      longint d1 [NTERM];
      longint d2 [NTERM];
      for (int i = 0; i < NREG; i++)
         v[i] = high_half ? longint'(signed'(endpoint_regs[i][63:32]))
                          : longint'(signed'(endpoint_regs[i][31:0]));
      c[0] = 2 * v[0];
      c[1] = 2 * v[1];
      c[2] = v[2];
      c[3] = -20*v[0] - 12*v[1] - 3*v[2] + 20*v[3] - 8*v[4] + v[5];
      c[4] = 30*v[0] + 16*v[1] + 3*v[2] - 30*v[3] + 14*v[4] - 2*v[5];
      c[5] = -12*v[0] - 6*v[1] - v[2] + 12*v[3] - 6*v[4] + v[5];
      foreach (d1[i]) begin
         d1[i] = 0;
         d2[i] = 0;
      end
      for (int i = 0; i < 5; i++) d1[i] = (i + 1) * c[i+1];
      for (int i = 0; i < 4; i++) d2[i] = (i + 2) * (i + 1) * c[i+2];
      pos   = horner_eval(c, 6, u);
      slope = horner_eval(d1, 5, u);
      bend  = horner_eval(d2, 4, u);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x    = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // |x'y'' - y'x''| / (S * floor(sqrt(S))), with S = x'^2 + y'^2.
   function automatic logic [31:0] curvature_of(longint x1, longint y1,
                                                longint x2, longint y2);
      longint       p1, p2;
      logic [63:0]  mag, s;
      logic [127:0] num, den;
      p1  = x1 * y2;
      p2  = y1 * x2;
      mag = (p1 >= p2) ? 64'(p1 - p2) : 64'(p2 - p1);
      s   = 64'(x1 * x1) + 64'(y1 * y1);
      // Near a stationary point the curvature is forced to zero.
      if (s <= STAT_LIMIT) return '0;
      num = {64'd0, mag} << (2 * FRAC_BITS);
      den = {64'd0, s} * {64'd0, int_sqrt(s)};
      if (num >= (den << WORD_BITS)) return '1;
      return 32'(num / den);
   endfunction

   function automatic logic [223:0] predict_sample(logic [17:0] raw_u);
      longint u, px, sx, bx, py, sy, by;
      u = longint'(signed'(raw_u));
      if (u < 0) u = 0;
      if (u > longint'(U_ONE)) u = longint'(U_ONE);
      eval_axis(1'b1, u, px, sx, bx);
      eval_axis(1'b0, u, py, sy, by);
      return {curvature_of(sx, sy, bx, by), 32'(by), 32'(bx),
              32'(sy), 32'(sx), 32'(py), 32'(px)};
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: predicts at request acceptance, checks at result acceptance.
   // ------------------------------------------------------------------------
   string field_names [7] = '{"pos_x", "pos_y", "slope_x", "slope_y",
                              "bend_x", "bend_y", "curvature"};

   always @(posedge clock) begin
      logic [223:0] want;
      param_taken  = 1'b0;
      any_activity = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_samples.push_back(predict_sample(req_tdata[17:0]));
            void'(pending_params.pop_front());
            accepted_count++;
            param_taken  = 1'b1;
            any_activity = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            any_activity = 1'b1;
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_samples.pop_front();
               for (int f = 0; f < 7; f++)
                  if (rsp_tdata[32*f +: 32] !== want[32*f +: 32]) begin
                     $display("%0t: %s expected %h actual %h", $time,
                              field_names[f], want[32*f +: 32], rsp_tdata[32*f +: 32]);
                     error_count++;
                  end
            end
         end
         if (csr_valid && csr_ready) any_activity = 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps.
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !param_taken) begin
         // The current request has not been taken yet; hold it.
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (pending_params.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tdata  <= {6'd0, pending_params[0]};
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver: its own stall pattern, plus one long hold-off.
   // ------------------------------------------------------------------------
   int  stall_mode = 0;
   int  mode_left  = 0;
   int  hold_left  = 0;
   bit  held_once  = 0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      if (!held_once && accepted_count >= 300) begin
         held_once = 1'b1;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Ends the run if nothing moves on any channel for too long.
   int idle_cycles = 0;
   always @(posedge clock) begin
      #1;
      if (reset || any_activity) begin
         idle_cycles = 0;
      end else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequencing.
   // ------------------------------------------------------------------------
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < NREG) endpoint_regs[idx] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits for every result, then lets the pipeline drain fully.
   task automatic settle();
      while (pending_params.size() != 0 || expected_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One signed Q16.16 half in a chosen magnitude class.
   function automatic logic [31:0] pick_half(int style);
      case (style)
         0: return 32'(int'($urandom_range(0, 32)) - 16);
         1: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         2: return $urandom();
         3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      endcase
   endfunction

   function automatic logic [17:0] pick_param();
      case ($urandom_range(0, 9))
         6, 7: return $urandom_range(0, 1) ? 18'(int'($urandom_range(0, 8)) - 4)
                                          : 18'(65532 + $urandom_range(0, 8));
         8: return 18'($urandom());
         9: return $urandom_range(0, 1) ? 18'd0 : 18'd65536;
         default: return 18'($urandom_range(0, 65536));
      endcase
   endfunction

   initial begin
      logic [17:0] edge_params [];
      edge_params = '{18'h20000, 18'h1ffff, 18'd0, 18'd65536,
                      18'd65535, 18'd1, 18'h3ffff, 18'd32768,
                      18'd65537, 18'h2aaaa, 18'h15555, 18'd16384,
                      18'd49152, 18'h3fff0, 18'd100};
      foreach (endpoint_regs[i]) endpoint_regs[i] = '0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset values first: a flat curve, stationary everywhere.
      foreach (edge_params[i]) pending_params.push_back(edge_params[i]);
      settle();

      // A moderate curve for the directed parameters, plus ignored indexes.
      for (int r = 0; r < NREG; r++)
         write_reg(CSR_IDX_W'(r), {pick_half(1), pick_half(1)});
      write_reg(3'd6, '1);
      write_reg(3'd7, 64'h8000_0000_7fff_ffff);
      foreach (edge_params[i]) pending_params.push_back(edge_params[i]);
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         for (int r = 0; r < NREG; r++)
            write_reg(CSR_IDX_W'(r),
                      {pick_half((phase + r) % 5), pick_half((phase + 2 * r) % 5)});
         if (phase == 7)
            for (int r = 0; r < NREG; r++) write_reg(CSR_IDX_W'(r), r[0] ? '0 : '1);
         for (int i = 0; i < 128; i++) pending_params.push_back(pick_param());
         settle();
      end

      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/qhe_pkg.sv
hdl/qhe_coef.sv
hdl/qhe_horner.sv
hdl/qhe_curv.sv
hdl/quintic_hermite_evaluator.sv
sim/tb.sv
